[hw/rtl/smnvm_pkg.sv]
// Package: item types, opcodes and helper functions for the nibble VM step block.
package smnvm_pkg;

    localparam int MEM_WORDS = 2048;
    localparam int ADDR_W    = 11;
    localparam logic [63:0] SEED_RESET = 64'hDEAD_BEEF_CAFE_BABE;

    typedef enum logic [3:0] {
        OP_NOP  = 4'h0,
        OP_INC  = 4'h1,
        OP_DEC  = 4'h2,
        OP_MOVR = 4'h3,
        OP_MOVL = 4'h4,
        OP_ADD  = 4'h5,
        OP_SUB  = 4'h6,
        OP_JZ   = 4'h7,
        OP_JNZ  = 4'h8,
        OP_OUT  = 4'h9,
        OP_IN   = 4'hA,
        OP_RND  = 4'hB,
        OP_CLR  = 4'hC,
        OP_SWP  = 4'hD,
        OP_CPY  = 4'hE,
        OP_HALT = 4'hF
    } op_t;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] address;
        logic [7:0]        write_byte;
        logic [7:0]        in_byte;
    } in_item_t;

    typedef struct packed {
        logic              out_valid;
        logic [7:0]        out_byte;
        logic [3:0]        opcode_done;
        logic              halted_now;
        logic [ADDR_W-1:0] ip_now;
        logic [ADDR_W-1:0] dp_now;
    } out_item_t;

    function automatic logic [63:0] xorshift_next(input logic [63:0] s);
        logic [63:0] s1;
        logic [63:0] s2;
        s1 = s ^ (s >> 12);
        s2 = s1 ^ (s1 << 25);
        return s2 ^ (s2 >> 27);
    endfunction

    // 268 mod 256 is 12, so the low byte is 8s + 4s
    function automatic logic [7:0] draw_byte(input logic [63:0] s);
        return (s[7:0] << 3) + (s[7:0] << 2);
    endfunction

endpackage

[hw/rtl/self_modifying_nibble_vm_step.sv]
// Top level: nibble VM step engine with shared code/data memory and one shared adder.
// Execute items step through FETCH, RDA, RDD, WR2 (SWP only) and DONE, as the single
// read port fetches the code byte, m[a] and m[dp] in turn; write items and halted
// steps go straight to DONE. No new item is taken until DONE has registered a result.
// Reset clears ip, dp and the halt flag and loads the generator with its seed value;
// memory contents are undefined until written, and no clearing pass is done.
module self_modifying_nibble_vm_step (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [63:0]           cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  smnvm_pkg::in_item_t   in_data,
    output logic                  res_valid,
    input  logic                  res_ready,
    output smnvm_pkg::out_item_t  res_data
);
    import smnvm_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FETCH = 6'b000010,
        S_RDA   = 6'b000100,
        S_RDD   = 6'b001000,
        S_WR2   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] ip_reg, ip_next;
    logic [ADDR_W-1:0] dp_reg, dp_next;
    logic              halt_reg, halt_next;
    logic [63:0]       rng_reg, rng_next;
    op_t               op_reg, op_next;
    logic [3:0]        arg_reg, arg_next;
    logic [7:0]        aval_reg, aval_next;
    logic [7:0]        inb_reg, inb_next;
    logic              ov_reg, ov_next;
    logic [7:0]        ob_reg, ob_next;
    logic [3:0]        opd_reg, opd_next;
    logic              res_valid_reg, res_valid_next;
    out_item_t         res_reg, res_next;

    logic [7:0]        mem [MEM_WORDS];
    logic [7:0]        rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;

    logic [ADDR_W-1:0] alu_a, alu_b, alu_sum;
    logic              alu_sub;
    logic              accept;
    logic              res_free;
    op_t               fetched_op;

    assign accept     = in_valid && in_ready;
    assign in_ready   = (state_reg == S_IDLE);
    assign res_free   = !res_valid_reg || res_ready;
    assign res_valid  = res_valid_reg;
    assign res_data   = res_reg;
    assign fetched_op = op_t'(rd_data_reg[7:4]);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign alu_sum = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        if (state_reg == S_FETCH)
        begin
            alu_a = ip_reg;
            alu_b = ADDR_W'(1);
        end
        else if (state_reg == S_RDD)
        begin
            case (op_reg)
                OP_INC, OP_DEC:
                begin
                    alu_a   = ADDR_W'(aval_reg);
                    alu_b   = ADDR_W'(1);
                    alu_sub = (op_reg == OP_DEC);
                end
                OP_MOVR, OP_MOVL:
                begin
                    alu_a   = dp_reg;
                    alu_b   = ADDR_W'(arg_reg);
                    alu_sub = (op_reg == OP_MOVL);
                end
                OP_ADD, OP_SUB:
                begin
                    alu_a   = ADDR_W'(rd_data_reg);
                    alu_b   = ADDR_W'(aval_reg);
                    alu_sub = (op_reg == OP_SUB);
                end
                OP_JZ, OP_JNZ:
                begin
                    alu_a   = ip_reg;
                    alu_b   = ADDR_W'(arg_reg);
                    alu_sub = (op_reg == OP_JNZ);
                end
                default:
                begin
                    alu_a = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ip_next        = ip_reg;
        dp_next        = dp_reg;
        halt_next      = halt_reg;
        rng_next       = rng_reg;
        op_next        = op_reg;
        arg_next       = arg_reg;
        aval_next      = aval_reg;
        inb_next       = inb_reg;
        ov_next        = ov_reg;
        ob_next        = ob_reg;
        opd_next       = opd_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        rd_addr        = ip_reg;
        wr_en          = 1'b0;
        wr_addr        = dp_reg;
        wr_data        = '0;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                rd_addr = ip_reg;
                if (accept)
                begin
                    ov_next  = 1'b0;
                    ob_next  = '0;
                    opd_next = '0;
                    inb_next = in_data.in_byte;
                    if (!in_data.mode)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = in_data.address;
                        wr_data    = in_data.write_byte;
                        state_next = S_DONE;
                    end
                    else if (halt_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                op_next    = fetched_op;
                arg_next   = rd_data_reg[3:0];
                ip_next    = alu_sum;
                rd_addr    = ADDR_W'(rd_data_reg[3:0]);
                state_next = S_RDA;
            end
            S_RDA:
            begin
                aval_next  = rd_data_reg;
                rd_addr    = dp_reg;
                state_next = S_RDD;
            end
            S_RDD:
            begin
                opd_next   = op_reg;
                wr_addr    = ADDR_W'(arg_reg);
                state_next = S_DONE;
                case (op_reg)
                    OP_INC, OP_DEC:
                    begin
                        wr_en   = 1'b1;
                        wr_data = alu_sum[7:0];
                    end
                    OP_MOVR, OP_MOVL:
                    begin
                        dp_next = alu_sum;
                    end
                    OP_ADD, OP_SUB:
                    begin
                        wr_en   = 1'b1;
                        wr_addr = dp_reg;
                        wr_data = alu_sum[7:0];
                    end
                    OP_JZ:
                    begin
                        if (rd_data_reg == 8'h00)
                        begin
                            ip_next = alu_sum;
                        end
                    end
                    OP_JNZ:
                    begin
                        if (rd_data_reg != 8'h00)
                        begin
                            ip_next = alu_sum;
                        end
                    end
                    OP_OUT:
                    begin
                        ov_next = 1'b1;
                        ob_next = aval_reg;
                    end
                    OP_IN:
                    begin
                        wr_en   = 1'b1;
                        wr_data = inb_reg;
                    end
                    OP_RND:
                    begin
                        rng_next = xorshift_next(rng_reg);
                        wr_en    = 1'b1;
                        wr_data  = draw_byte(rng_next);
                    end
                    OP_CLR:
                    begin
                        wr_en   = 1'b1;
                        wr_data = 8'h00;
                    end
                    OP_SWP:
                    begin
                        wr_en      = 1'b1;
                        wr_data    = rd_data_reg;
                        state_next = S_WR2;
                    end
                    OP_CPY:
                    begin
                        wr_en   = 1'b1;
                        wr_data = rd_data_reg;
                    end
                    OP_HALT:
                    begin
                        halt_next = 1'b1;
                    end
                    default:
                    begin
                        wr_en = 1'b0;
                    end
                endcase
            end
            S_WR2:
            begin
                wr_en      = 1'b1;
                wr_addr    = dp_reg;
                wr_data    = aval_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_free)
                begin
                    res_valid_next       = 1'b1;
                    res_next.out_valid   = ov_reg;
                    res_next.out_byte    = ob_reg;
                    res_next.opcode_done = opd_reg;
                    res_next.halted_now  = halt_reg;
                    res_next.ip_now      = ip_reg;
                    res_next.dp_now      = dp_reg;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr_en)
        begin
            rng_next = cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ip_reg        <= '0;
            dp_reg        <= '0;
            halt_reg      <= 1'b0;
            rng_reg       <= SEED_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ip_reg        <= ip_next;
            dp_reg        <= dp_next;
            halt_reg      <= halt_next;
            rng_reg       <= rng_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        arg_reg  <= arg_next;
        aval_reg <= aval_next;
        inb_reg  <= inb_next;
        ov_reg   <= ov_next;
        ob_reg   <= ob_next;
        opd_reg  <= opd_next;
        res_reg  <= res_next;
    end

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg)
        else $error("halt flag cleared without reset");

    a_exec_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.mode && !halt_reg) |=> (state_reg == S_FETCH))
        else $error("execute item did not start a fetch");

    a_wr2_only_swp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR2) |-> ($past(state_reg == S_RDD) && (op_reg == OP_SWP)))
        else $error("second write outside a swap");

endmodule

[tb/self_modifying_nibble_vm_step_tb.sv]
// Testbench for the nibble VM step block: directed program, random programs, seed changes, halt.
module self_modifying_nibble_vm_step_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import smnvm_pkg::*;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_EXEC  = 1'b1;
    localparam int   CYCLE_LIMIT = 300000;
    localparam int   PHASES      = 6;
    localparam int   PHASE_ITEMS = 310;

    class vm_step_scoreboard;
        logic [7:0]        mem [MEM_WORDS];
        bit                written [MEM_WORDS];
        logic [ADDR_W-1:0] ip;
        logic [ADDR_W-1:0] dp;
        bit                halted;
        logic [63:0]       rng;
        out_item_t         expected_steps [$];
        int                items_in;
        int                writes_in;
        int                steps_in;
        int                results_seen;
        int                mismatches;
        int                draws;
        int                bytes_out;
        int                op_hits [16];

        function new();
            foreach (mem[i]) begin
                mem[i] = 8'd0;
                written[i] = 1'b0;
            end
            foreach (op_hits[i]) op_hits[i] = 0;
            ip = '0;
            dp = '0;
            halted = 1'b0;
            rng = SEED_RESET;
            items_in = 0;
            writes_in = 0;
            steps_in = 0;
            results_seen = 0;
            mismatches = 0;
            draws = 0;
            bytes_out = 0;
        endfunction

        function void set_seed(input logic [63:0] s);
            rng = s;
        endfunction

        function logic [7:0] next_random();
            rng = rng ^ (rng >> 12);
            rng = rng ^ (rng << 25);
            rng = rng ^ (rng >> 27);
            draws++;
            return 8'(rng * 64'd268);
        endfunction

        function void apply_item(input in_item_t it);
            out_item_t         r;
            logic [7:0]        word;
            logic [7:0]        tmp;
            logic [3:0]        arg;
            logic [ADDR_W-1:0] ai;
            logic [ADDR_W-1:0] d;
            op_t               op;
            r = '0;
            items_in++;
            if (it.mode == MODE_WRITE) begin
                mem[it.address] = it.write_byte;
                written[it.address] = 1'b1;
                writes_in++;
            end else begin
                steps_in++;
                if (!halted) begin
                    word = mem[ip];
                    op = op_t'(word[7:4]);
                    arg = word[3:0];
                    ai = ADDR_W'(arg);
                    d = dp;
                    ip = ip + ADDR_W'(1);
                    r.opcode_done = op;
                    op_hits[op]++;
                    case (op)
                        OP_INC:  mem[ai] = mem[ai] + 8'd1;
                        OP_DEC:  mem[ai] = mem[ai] - 8'd1;
                        OP_MOVR: dp = d + ai;
                        OP_MOVL: dp = d - ai;
                        OP_ADD:  mem[d] = mem[d] + mem[ai];
                        OP_SUB:  mem[d] = mem[d] - mem[ai];
                        OP_JZ:   if (mem[d] == 8'd0) ip = ip + ai;
                        OP_JNZ:  if (mem[d] != 8'd0) ip = ip - ai;
                        OP_OUT:
                        begin
                            r.out_valid = 1'b1;
                            r.out_byte = mem[ai];
                            bytes_out++;
                        end
                        OP_IN:   mem[ai] = it.in_byte;
                        OP_RND:  mem[ai] = next_random();
                        OP_CLR:  mem[ai] = 8'd0;
                        OP_SWP:
                        begin
                            tmp = mem[ai];
                            mem[ai] = mem[d];
                            mem[d] = tmp;
                        end
                        OP_CPY:  mem[ai] = mem[d];
                        OP_HALT: halted = 1'b1;
                        default: ;
                    endcase
                end
            end
            r.halted_now = halted;
            r.ip_now = ip;
            r.dp_now = dp;
            expected_steps.push_back(r);
        endfunction

        task report(input string what, input logic [63:0] want, input logic [63:0] got);
            mismatches++;
            if (mismatches <= 40)
                $display("MISMATCH at result %0d, %s: expected %0h, got %0h",
                         results_seen, what, want, got);
        endtask

        task compare_result(input out_item_t got);
            out_item_t want;
            if (expected_steps.size() == 0) begin
                report("result with no item outstanding", '0, 64'(got));
            end else begin
                want = expected_steps.pop_front();
                results_seen++;
                if (got.out_valid !== want.out_valid)
                    report("out_valid", 64'(want.out_valid), 64'(got.out_valid));
                if (got.out_byte !== want.out_byte)
                    report("out_byte", 64'(want.out_byte), 64'(got.out_byte));
                if (got.opcode_done !== want.opcode_done)
                    report("opcode_done", 64'(want.opcode_done), 64'(got.opcode_done));
                if (got.halted_now !== want.halted_now)
                    report("halted_now", 64'(want.halted_now), 64'(got.halted_now));
                if (got.ip_now !== want.ip_now)
                    report("ip_now", 64'(want.ip_now), 64'(got.ip_now));
                if (got.dp_now !== want.dp_now)
                    report("dp_now", 64'(want.dp_now), 64'(got.dp_now));
            end
        endtask

        function int kinds_run();
            int n;
            n = 0;
            foreach (op_hits[i]) if (op_hits[i] != 0) n++;
            return n;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [63:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_data = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    out_item_t   res_data;

    vm_step_scoreboard sb = new();
    bit steady = 1'b0;
    int cycle_count = 0;

    self_modifying_nibble_vm_step dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, sb.expected_steps.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off once the block has taken enough items
    initial
    begin
        int  hold_left;
        bit  held;
        hold_left = 0;
        held = 1'b0;
        forever begin
            @(posedge clk);
            if (res_valid && res_ready)
                sb.compare_result(res_data);
            if (!held && sb.items_in >= 450) begin
                hold_left = 300;
                held = 1'b1;
            end
            if (!rst_n) begin
                res_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                res_ready <= 1'b0;
            end else begin
                res_ready <= steady || ($urandom_range(99) >= 23);
            end
        end
    end

    function automatic logic [7:0] code_byte();
        return {4'($urandom_range(OP_CPY)), 4'($urandom_range(15))};
    endfunction

    function automatic logic [7:0] data_byte();
        return ($urandom_range(3) == 0) ? 8'd0 : code_byte();
    endfunction

    task automatic send_item(input in_item_t it);
        while (!steady && $urandom_range(99) < 23) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (!in_ready);
        sb.apply_item(it);
    endtask

    task automatic put_byte(input logic [ADDR_W-1:0] spot, input logic [7:0] val);
        in_item_t it;
        it.mode = MODE_WRITE;
        it.address = spot;
        it.write_byte = val;
        it.in_byte = 8'($urandom);
        send_item(it);
    endtask

    // write each cell the next step reads that was never written; re-code a HALT at ip unless allowed
    task automatic step_vm(input bit allow_halt, input logic [7:0] feed);
        in_item_t   it;
        logic [3:0] arg;
        bit         runnable;
        runnable = 1'b0;
        while (!runnable) begin
            runnable = 1'b1;
            arg = sb.mem[sb.ip][3:0];
            if (!sb.written[sb.ip] ||
                (!allow_halt && !sb.halted && sb.mem[sb.ip][7:4] == OP_HALT)) begin
                put_byte(sb.ip, code_byte());
                runnable = 1'b0;
            end else if (!sb.halted && !sb.written[ADDR_W'(arg)]) begin
                put_byte({7'd0, arg}, data_byte());
                runnable = 1'b0;
            end else if (!sb.halted && !sb.written[sb.dp]) begin
                put_byte(sb.dp, data_byte());
                runnable = 1'b0;
            end
        end
        it.mode = MODE_EXEC;
        it.address = ADDR_W'($urandom);
        it.write_byte = 8'($urandom);
        it.in_byte = feed;
        send_item(it);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.expected_steps.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic load_seed(input logic [63:0] s);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= s;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_seed(s);
    endtask

    task automatic run_directed();
        logic [7:0] prog [15];
        prog = '{{OP_IN, 4'd0}, {OP_INC, 4'd0}, {OP_JZ, 4'd1}, {OP_DEC, 4'd0},
                 {OP_OUT, 4'd0}, {OP_MOVR, 4'd2}, {OP_ADD, 4'd1}, {OP_SUB, 4'd0},
                 {OP_JNZ, 4'd0}, {OP_RND, 4'd1}, {OP_CLR, 4'd0}, {OP_SWP, 4'd1},
                 {OP_CPY, 4'd0}, {OP_NOP, 4'd0}, {OP_MOVL, 4'd15}};
        // the taken JZ skips cell 3, so it is never written
        foreach (prog[i]) begin
            put_byte((i < 3) ? ADDR_W'(i) : ADDR_W'(i + 1), prog[i]);
            step_vm(1'b0, 8'hFF);
        end
        put_byte({ADDR_W{1'b1}}, 8'hFF);
    endtask

    task automatic random_burst();
        int unsigned       pick;
        int unsigned       k;
        logic [ADDR_W-1:0] spot;
        pick = $urandom_range(99);
        if (pick < 50) begin
            k = $urandom_range(8, 2);
            spot = sb.ip;
            repeat (k) begin
                put_byte(spot, code_byte());
                spot = spot + ADDR_W'(1);
            end
            repeat (k + $urandom_range(2)) step_vm(1'b0, 8'($urandom));
        end else if (pick < 65) begin
            repeat ($urandom_range(3, 1)) put_byte(ADDR_W'($urandom_range(15)), data_byte());
            put_byte(sb.dp, data_byte());
        end else if (pick < 80) begin
            put_byte(ADDR_W'($urandom), 8'($urandom));
        end else begin
            repeat ($urandom_range(4, 1)) step_vm(1'b0, 8'($urandom));
        end
    endtask

    task automatic run_halt();
        while (!sb.halted) begin
            put_byte(sb.dp, data_byte());
            put_byte(sb.ip, {OP_HALT, 4'($urandom)});
            step_vm(1'b1, 8'($urandom));
        end
        repeat (3) step_vm(1'b1, 8'($urandom));
        put_byte(ADDR_W'($urandom), 8'($urandom));
        step_vm(1'b1, 8'($urandom));
        put_byte(ADDR_W'($urandom), 8'($urandom));
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                settle();
                case (p)
                    1:       load_seed(64'd0);
                    2:       load_seed({64{1'b1}});
                    4:       load_seed(64'd1);
                    default: load_seed({$urandom, $urandom});
                endcase
            end
            steady = (p == 2);
            while (sb.items_in < 30 + (p + 1) * PHASE_ITEMS) random_burst();
        end
        steady = 1'b0;
        settle();
        run_halt();
        settle();
        repeat (12) @(posedge clk);
        $display("Covered %0d items (%0d writes, %0d steps), %0d results checked, %0d mismatches",
                 sb.items_in, sb.writes_in, sb.steps_in, sb.results_seen, sb.mismatches);
        $display("Executed %0d of 16 opcodes, %0d random draws, %0d output bytes, 6 seeds",
                 sb.kinds_run(), sb.draws, sb.bytes_out);
        if (sb.mismatches == 0 && sb.expected_steps.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/smnvm_pkg.sv
hw/rtl/self_modifying_nibble_vm_step.sv
tb/self_modifying_nibble_vm_step_tb.sv
